// ----- sv/wsd_pkg.sv -----
// Package for the WebSocket frame deframer: shared types, codes and constants.
// Used by wsd_front, wsd_queue, wsd_back and websocket_frame_deframer.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] MaxFrameSizeReset = 16'hffff;
  localparam logic [6:0]  LenExt16          = 7'd126;
  localparam logic [6:0]  LenExt64          = 7'd127;
  localparam logic [3:0]  OpClose           = 4'h8;
  localparam logic [3:0]  HdrExt16Done      = 4'd4;
  localparam logic [3:0]  HdrExt64Done      = 4'd10;
  localparam logic [1:0]  LastKeyIdx        = 2'd3;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_BIG   = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    PH_FIRST = 6'b000001,
    PH_LEN   = 6'b000010,
    PH_EXT16 = 6'b000100,
    PH_EXT64 = 6'b001000,
    PH_MASK  = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic       frame_end;
  } entry_t;

endpackage

// ----- sv/wsd_front.sv -----
// Front part of the deframer: parses frame headers and classifies each byte.
// Depends on wsd_pkg; pushes one entry per result into wsd_queue.
`timescale 1ns / 1ps

module wsd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  input  logic [15:0]     max_frame_size_i,
  output logic            push_o,
  output wsd_pkg::entry_t entry_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_q, hdr_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  midx_q, midx_d;
  logic        close_q, close_d;
  logic        halted_q, halted_d;

  logic [3:0]  hdr_inc;
  logic [16:0] size_sum;
  logic        too_large;
  logic        last_byte;
  logic [7:0]  key_byte;
  logic [6:0]  len7;

  assign hdr_inc   = hdr_q + 4'd1;
  assign size_sum  = {1'b0, remain_q[15:0]} + {13'd0, hdr_inc};
  assign too_large = (|remain_q[63:16]) || (size_sum >= {1'b0, max_frame_size_i});
  assign last_byte = (remain_q == 64'd1);
  assign len7      = rx_byte_i[6:0];

  always_comb begin
    case (midx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    remain_d = remain_q;
    key_d    = key_q;
    midx_d   = midx_q;
    close_d  = close_q;
    halted_d = halted_q;
    push_o   = 1'b0;
    entry_o  = '{kind: KIND_DATA, raw: 8'd0, key: 8'd0, frame_end: 1'b1};
    if (accept_i && !halted_q) begin
      unique case (phase_q)
        PH_FIRST: begin
          close_d  = (rx_byte_i[3:0] == OpClose);
          hdr_d    = 4'd1;
          remain_d = 64'd0;
          key_d    = 32'd0;
          midx_d   = 2'd0;
          phase_d  = PH_LEN;
        end
        PH_LEN: begin
          hdr_d = 4'd2;
          if (len7 == LenExt16) begin
            phase_d = PH_EXT16;
          end else if (len7 == LenExt64) begin
            phase_d = PH_EXT64;
          end else begin
            remain_d = {57'd0, len7};
            phase_d  = PH_MASK;
          end
        end
        PH_EXT16, PH_EXT64: begin
          remain_d = {remain_q[55:0], rx_byte_i};
          hdr_d    = hdr_inc;
          if ((phase_q == PH_EXT16 && hdr_inc >= HdrExt16Done) ||
              (phase_q == PH_EXT64 && hdr_inc >= HdrExt64Done)) begin
            phase_d = PH_MASK;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          hdr_d = hdr_inc;
          if (midx_q != LastKeyIdx) begin
            midx_d = midx_q + 2'd1;
          end else begin
            midx_d = 2'd0;
            if (too_large) begin
              halted_d      = 1'b1;
              push_o        = 1'b1;
              entry_o.kind  = KIND_BIG;
            end else if (remain_q == 64'd0) begin
              phase_d = PH_FIRST;
              push_o  = 1'b1;
              if (close_q) begin
                halted_d     = 1'b1;
                entry_o.kind = KIND_CLOSE;
              end else begin
                entry_o.kind = KIND_EMPTY;
              end
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          midx_d   = midx_q + 2'd1;
          remain_d = remain_q - 64'd1;
          if (last_byte) begin
            phase_d = PH_FIRST;
          end
          if (close_q) begin
            if (last_byte) begin
              halted_d     = 1'b1;
              push_o       = 1'b1;
              entry_o.kind = KIND_CLOSE;
            end
          end else begin
            push_o  = 1'b1;
            entry_o = '{kind: KIND_DATA, raw: rx_byte_i, key: key_byte,
                        frame_end: last_byte};
          end
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      hdr_q    <= 4'd0;
      remain_q <= 64'd0;
      key_q    <= 32'd0;
      midx_q   <= 2'd0;
      close_q  <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      remain_q <= remain_d;
      key_q    <= key_d;
      midx_q   <= midx_d;
      close_q  <= close_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ----- sv/wsd_queue.sv -----
// Short first-in first-out queue of result entries between front and back.
// Depends on wsd_pkg for the entry type.
`timescale 1ns / 1ps

module wsd_queue #(
  parameter int unsigned Depth = wsd_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  wsd_pkg::entry_t wdata_i,
  input  logic            rd_i,
  output wsd_pkg::entry_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  import wsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- sv/wsd_back.sv -----
// Back part of the deframer: unmasks queued entries into the result register.
// Depends on wsd_pkg; drains wsd_queue and drives the result side.
`timescale 1ns / 1ps

module wsd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  wsd_pkg::entry_t q_data_i,
  output logic            q_rd_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [1:0]      kind_o,
  output logic [7:0]      payload_byte_o,
  output logic            frame_end_o
);
  import wsd_pkg::*;

  logic       valid_q;
  kind_e      kind_q;
  logic [7:0] byte_q;
  logic       end_q;

  assign q_rd_o  = !q_empty_i && (!valid_q || pop_i);
  assign empty_o = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      kind_q <= q_data_i.kind;
      byte_q <= q_data_i.raw ^ q_data_i.key;
      end_q  <= q_data_i.frame_end;
    end
  end

  assign kind_o         = kind_q;
  assign payload_byte_o = byte_q;
  assign frame_end_o    = end_q;

endmodule

// ----- sv/websocket_frame_deframer.sv -----
// WebSocket frame deframer: usage notes.
// Received bytes enter on rx_byte_i through a queue-style port: a byte is
// taken at a clock edge where push is high and full is low. Results leave
// through a queue-style port: while empty is low, kind_o, payload_byte_o and
// frame_end_o show the oldest result, and it is taken where pop is high.
// Header bytes give no result; payload bytes are unmasked and given as
// payload results; an empty data frame, a close frame or an oversized frame
// gives one result marked as frame end. After a close or oversize result
// the block takes further bytes and drops them until reset.
// One byte is taken in every cycle while full is low; when the receiver
// keeps up, the parser writes each result into the queue as its byte is
// taken, and the queue entry then moves into the unmask register that
// drives the outputs.
// A receiver that stalls fills the two-entry queue and the result register;
// full then rises and no byte is lost. Reset clears the parser, the queue
// and the result register and sets max_frame_size to 65535.
// The limit register sits at address 0 of the APB port; the user must write
// it only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module websocket_frame_deframer #(
  parameter int unsigned QDepth = wsd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        frame_end_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wsd_pkg::*;

  logic [15:0] max_size_q;
  logic        accept;
  logic        f_push;
  entry_t      f_entry;
  entry_t      q_data;
  logic        q_empty;
  logic        q_rd;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, max_size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MaxFrameSizeReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_size_q <= pwdata[15:0];
    end
  end

  assign accept = push && !full;

  wsd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .rx_byte_i        (rx_byte_i),
    .max_frame_size_i (max_size_q),
    .push_o           (f_push),
    .entry_o          (f_entry)
  );

  wsd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_push),
    .wdata_i (f_entry),
    .rd_i    (q_rd),
    .rdata_o (q_data),
    .full_o  (full),
    .empty_o (q_empty)
  );

  wsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_data),
    .q_rd_o         (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_end_o    (frame_end_o)
  );

endmodule
